// ===== rtl/clni_pkg.sv =====
// ----------------------------------------------------------------------------
// clni_pkg
// Types, codes and the operation programs of the character-LCD 4-bit bus
// driver.
// ----------------------------------------------------------------------------
`default_nettype none

package clni_pkg;

    // request codes on the input stream
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_COMMAND = 3'd1;
    localparam logic [2:0] CMD_DATA    = 3'd2;
    localparam logic [2:0] CMD_CURSOR  = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;
    localparam logic [2:0] CMD_INIT    = 3'd5;

    // running operation; clear and init carry the layout they started with
    localparam logic [2:0] OP_IDLE    = 3'd0;
    localparam logic [2:0] OP_COMMAND = 3'd1;
    localparam logic [2:0] OP_DATA    = 3'd2;
    localparam logic [2:0] OP_CURSOR  = 3'd3;
    localparam logic [2:0] OP_CLEAR2  = 3'd4;
    localparam logic [2:0] OP_INIT2   = 3'd5;
    localparam logic [2:0] OP_CLEAR4  = 3'd6;
    localparam logic [2:0] OP_INIT4   = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_FOUR_ROW = 2'd0;
    localparam logic [1:0] CFG_ENABLE   = 2'd1;
    localparam logic [1:0] CFG_GAP      = 2'd2;
    localparam logic [1:0] CFG_MS       = 2'd3;

    // display instruction bytes
    localparam logic [7:0] LCD_WAKE      = 8'h30;
    localparam logic [7:0] LCD_FOUR_BIT  = 8'h20;
    localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
    localparam logic [7:0] LCD_DISP_OFF  = 8'h08;
    localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
    localparam logic [7:0] LCD_SHIFT     = 8'h18;
    localparam logic [7:0] LCD_ENTRY     = 8'h06;
    localparam logic [7:0] LCD_HOME      = 8'h02;
    localparam logic [7:0] LCD_CLEAR     = 8'h01;
    localparam logic [7:0] LCD_DDRAM_SET = 8'h80;

    // row start addresses of the four-row layout, and the two-row second row
    localparam logic [6:0] ROW_BASE4 [4] = '{7'h00, 7'h40, 7'h14, 7'h54};
    localparam logic [6:0] ROW_BASE2     = 7'h40;

    // one step of an operation program
    typedef enum logic [2:0] {
        K_END  = 3'd0,
        K_NIB  = 3'd1,
        K_BYTE = 3'd2,
        K_HOLD = 3'd3,
        K_MS   = 3'd4,
        K_GAP  = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] arg;
    } t_act;

    // program step lookup, steps past the end read as end of program
    function automatic t_act prog_act(input logic [2:0] op, input logic [4:0] step);
        t_act a;
        a = '{kind: K_END, arg: 8'h00};
        case (op)
            OP_COMMAND, OP_DATA: begin
                if (step == 5'd0) a = '{kind: K_HOLD, arg: 8'h00};
            end
            OP_CURSOR: begin
                case (step)
                    5'd0:    a = '{kind: K_HOLD, arg: 8'h00};
                    5'd1:    a = '{kind: K_GAP, arg: 8'h00};
                    default: a = '{kind: K_END, arg: 8'h00};
                endcase
            end
            OP_CLEAR2: begin
                case (step)
                    5'd0:    a = '{kind: K_BYTE, arg: LCD_CLEAR};
                    5'd1:    a = '{kind: K_MS, arg: 8'd20};
                    default: a = '{kind: K_END, arg: 8'h00};
                endcase
            end
            OP_INIT2: begin
                case (step)
                    5'd0:    a = '{kind: K_BYTE, arg: LCD_FOUR_BIT};
                    5'd1:    a = '{kind: K_MS, arg: 8'd10};
                    5'd2:    a = '{kind: K_BYTE, arg: LCD_FOUR_BIT};
                    5'd3:    a = '{kind: K_MS, arg: 8'd10};
                    5'd4:    a = '{kind: K_BYTE, arg: LCD_SHIFT};
                    5'd5:    a = '{kind: K_MS, arg: 8'd20};
                    5'd6:    a = '{kind: K_BYTE, arg: LCD_DISP_ON};
                    5'd7:    a = '{kind: K_MS, arg: 8'd20};
                    5'd8:    a = '{kind: K_BYTE, arg: LCD_ENTRY};
                    5'd9:    a = '{kind: K_MS, arg: 8'd20};
                    5'd10:   a = '{kind: K_BYTE, arg: LCD_HOME};
                    5'd11:   a = '{kind: K_MS, arg: 8'd20};
                    5'd12:   a = '{kind: K_BYTE, arg: LCD_CLEAR};
                    5'd13:   a = '{kind: K_MS, arg: 8'd20};
                    default: a = '{kind: K_END, arg: 8'h00};
                endcase
            end
            OP_CLEAR4: begin
                case (step)
                    5'd0:    a = '{kind: K_BYTE, arg: LCD_CLEAR};
                    5'd1:    a = '{kind: K_MS, arg: 8'd20};
                    5'd2:    a = '{kind: K_BYTE, arg: LCD_ENTRY};
                    5'd3:    a = '{kind: K_MS, arg: 8'd1};
                    default: a = '{kind: K_END, arg: 8'h00};
                endcase
            end
            OP_INIT4: begin
                case (step)
                    5'd0:    a = '{kind: K_MS, arg: 8'd20};
                    5'd1:    a = '{kind: K_NIB, arg: LCD_WAKE};
                    5'd2:    a = '{kind: K_MS, arg: 8'd10};
                    5'd3:    a = '{kind: K_NIB, arg: LCD_WAKE};
                    5'd4:    a = '{kind: K_MS, arg: 8'd1};
                    5'd5:    a = '{kind: K_NIB, arg: LCD_WAKE};
                    5'd6:    a = '{kind: K_MS, arg: 8'd1};
                    5'd7:    a = '{kind: K_NIB, arg: LCD_FOUR_BIT};
                    5'd8:    a = '{kind: K_MS, arg: 8'd1};
                    5'd9:    a = '{kind: K_BYTE, arg: LCD_FUNC_SET};
                    5'd10:   a = '{kind: K_MS, arg: 8'd1};
                    5'd11:   a = '{kind: K_BYTE, arg: LCD_DISP_OFF};
                    5'd12:   a = '{kind: K_MS, arg: 8'd1};
                    5'd13:   a = '{kind: K_BYTE, arg: LCD_CLEAR};
                    5'd14:   a = '{kind: K_MS, arg: 8'd1};
                    5'd15:   a = '{kind: K_BYTE, arg: LCD_ENTRY};
                    5'd16:   a = '{kind: K_MS, arg: 8'd1};
                    5'd17:   a = '{kind: K_BYTE, arg: LCD_DISP_ON};
                    5'd18:   a = '{kind: K_MS, arg: 8'd1};
                    default: a = '{kind: K_END, arg: 8'h00};
                endcase
            end
            default: a = '{kind: K_END, arg: 8'h00};
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/char_lcd_nibble_interface.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface
// 4-bit character-LCD bus driver: each input transfer is one timer tick that
// may start a request and advances nibble writes and delays.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  s stream  in         i_s_tvalid / o_s_tready   one tick with request fields
//  m stream  out        o_m_tvalid / i_m_tready   pin levels after that tick
//  cfg write in         i_cfg_valid / o_cfg_ready register index and data
//
//  one tick is accepted every cycle while o_s_tready is high; its result is
//  registered and shows on the m stream in the cycle after it is accepted
//  the input is taken whenever the result register is empty or being drained,
//  so a stalled m side holds the s side after one buffered result
//  i_rst_n (synchronous) clears the sequencer, pins and result register and
//  loads the register defaults; cfg writes are always taken
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_interface
    import clni_pkg::*;
#(
    parameter int WAIT_WIDTH = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [2:0] cmd, [10:3] value, [17:11] col, [19:18] row, [21:20] side_bits
    input  wire logic [23:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [3:0] data_nibble, [4] reg_select, [5] enable_pin, [7:6] side_out,
    // [8] busy_res, [9] accepted
    output logic [15:0]      o_m_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam logic [32:0] WAIT_MAX = (33'd1 << WAIT_WIDTH) - 33'd1;

    // delay length clamp: zero counts as one tick, long delays saturate
    function automatic logic [WAIT_WIDTH-1:0] sat_wait(input logic [23:0] n);
        logic [WAIT_WIDTH-1:0] res;
        if (n == 24'd0) begin
            res = WAIT_WIDTH'(1);
        end else if (33'(n) > WAIT_MAX) begin
            res = '1;
        end else begin
            res = WAIT_WIDTH'(n);
        end
        return res;
    endfunction

    // configuration registers
    logic        r_four_row;
    logic [7:0]  r_enable_ticks;
    logic [15:0] r_gap_ticks;
    logic [15:0] r_ms_ticks;

    // sequencer state
    logic [4:0]            r_step,  n_step;
    logic [WAIT_WIDTH-1:0] r_wait,  n_wait;
    logic [7:0]            r_byte,  n_byte;
    logic                  r_rs,    n_rs;
    logic                  r_low,   n_low;
    logic [2:0]            r_op,    n_op;
    // port image: data[7:4], side[3:2], rs[1], enable[0]
    logic [7:0]            r_pin,   n_pin;

    // result register
    logic                  r_out_valid;
    logic [9:0]            r_out;

    // input fields
    logic [2:0] in_cmd;
    logic [7:0] in_value;
    logic [6:0] in_col;
    logic [1:0] in_row;
    logic [1:0] in_side;

    logic       s_fire;
    logic       acc;
    logic       do_start;
    t_act       act;
    logic [7:0] cursor_addr;
    logic [WAIT_WIDTH-1:0] en_wait;
    logic [WAIT_WIDTH-1:0] gap_wait;

    assign in_cmd   = i_s_tdata[2:0];
    assign in_value = i_s_tdata[10:3];
    assign in_col   = i_s_tdata[17:11];
    assign in_row   = i_s_tdata[19:18];
    assign in_side  = i_s_tdata[21:20];

    // handshakes
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign s_fire      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // cursor address for both layouts
    always_comb begin
        if (r_four_row) begin
            cursor_addr = LCD_DDRAM_SET | {1'b0, 7'(in_col + ROW_BASE4[in_row])};
        end else if (in_row == 2'd0) begin
            cursor_addr = LCD_DDRAM_SET | {1'b0, in_col};
        end else begin
            cursor_addr = LCD_DDRAM_SET | {1'b0, 7'(ROW_BASE2 + in_col)};
        end
    end

    // phase lengths
    assign en_wait    = sat_wait(24'(r_enable_ticks));
    assign gap_wait   = sat_wait(24'(r_gap_ticks));

    // next sequencer state for one tick
    always_comb begin
        n_step   = r_step;
        n_wait   = r_wait;
        n_byte   = r_byte;
        n_rs     = r_rs;
        n_low    = r_low;
        n_op     = r_op;
        n_pin    = r_pin;
        acc      = 1'b0;
        do_start = 1'b0;

        if (r_op == OP_IDLE) begin
            if (in_cmd inside {[CMD_COMMAND:CMD_INIT]}) begin
                acc      = 1'b1;
                do_start = 1'b1;
                n_step   = 5'd0;
                n_rs     = (in_cmd == CMD_DATA);
                n_byte   = 8'h00;
                case (in_cmd)
                    CMD_COMMAND: begin
                        n_byte = in_value;
                        n_op   = OP_COMMAND;
                    end
                    CMD_DATA: begin
                        n_byte = in_value;
                        n_op   = OP_DATA;
                    end
                    CMD_CURSOR: begin
                        n_byte = cursor_addr;
                        n_op   = OP_CURSOR;
                    end
                    CMD_CLEAR: n_op = r_four_row ? OP_CLEAR4 : OP_CLEAR2;
                    default:   n_op = r_four_row ? OP_INIT4 : OP_INIT2;
                endcase
            end
        end else if (r_wait > WAIT_WIDTH'(1)) begin
            n_wait = r_wait - WAIT_WIDTH'(1);
        end else if (r_pin[0]) begin
            n_pin[0] = 1'b0;
            n_wait   = gap_wait;
        end else if (r_low) begin
            n_low  = 1'b0;
            n_pin  = {r_byte[3:0], in_side, r_rs, 1'b1};
            n_wait = en_wait;
        end else begin
            n_step   = r_step + 5'd1;
            do_start = 1'b1;
        end

        act = prog_act(n_op, n_step);

        // start the program step
        if (do_start) begin
            n_low = 1'b0;
            case (act.kind)
                K_NIB: begin
                    n_pin  = {act.arg[7:4], 2'b00, 1'b0, 1'b1};
                    n_wait = en_wait;
                end
                K_BYTE: begin
                    n_byte = act.arg;
                    n_low  = 1'b1;
                    n_pin  = {act.arg[7:4], in_side, n_rs, 1'b1};
                    n_wait = en_wait;
                end
                K_HOLD: begin
                    n_low  = 1'b1;
                    n_pin  = {n_byte[7:4], in_side, n_rs, 1'b1};
                    n_wait = en_wait;
                end
                K_MS:  n_wait = sat_wait(24'(act.arg) * 24'(r_ms_ticks));
                K_GAP: n_wait = gap_wait;
                default: begin
                    n_op   = OP_IDLE;
                    n_step = 5'd0;
                    n_wait = '0;
                end
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_row     <= 1'b0;
            r_enable_ticks <= 8'd2;
            r_gap_ticks    <= 16'd200;
            r_ms_ticks     <= 16'd1000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FOUR_ROW: r_four_row     <= i_cfg_data[0];
                CFG_ENABLE:   r_enable_ticks <= i_cfg_data[7:0];
                CFG_GAP:      r_gap_ticks    <= i_cfg_data;
                CFG_MS:       r_ms_ticks     <= i_cfg_data;
                default:      r_ms_ticks     <= r_ms_ticks;
            endcase
        end
    end

    // sequencer state update per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 5'd0;
            r_wait <= '0;
            r_byte <= 8'h00;
            r_rs   <= 1'b0;
            r_low  <= 1'b0;
            r_op   <= OP_IDLE;
            r_pin  <= 8'h00;
        end else if (s_fire) begin
            r_step <= n_step;
            r_wait <= n_wait;
            r_byte <= n_byte;
            r_rs   <= n_rs;
            r_low  <= n_low;
            r_op   <= n_op;
            r_pin  <= n_pin;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out <= {acc, (n_op != OP_IDLE), n_pin[3:2], n_pin[0], n_pin[1], n_pin[7:4]};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b000000, r_out};

    // enable strobe only rises inside a running operation
    a_enable_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pin[0] |-> (r_op != OP_IDLE))
        else $error("enable high while idle");

    // a pending low nibble belongs to a running operation
    a_low_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low |-> (r_op != OP_IDLE))
        else $error("low nibble pending while idle");

    // a running phase always has ticks left
    a_wait_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op != OP_IDLE) |-> (r_wait != '0))
        else $error("running operation with empty wait count");

    // requests are refused while busy
    a_refuse_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && (r_op != OP_IDLE)) |=> !r_out[9])
        else $error("request accepted while busy");

    // every accepted tick leaves a result in the output register
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_out_valid)
        else $error("accepted tick produced no result");

endmodule

`default_nettype wire
